[rtl/core/mtd_pkg.sv]
// mtd_pkg: constants, result bundle and Morse lookup for the Morse text decoder.
// No dependencies; imported by mtd_token, morse_text_decoder and the testbench.
package mtd_pkg;

    localparam int MAX_TOKEN = 9;
    localparam int LEN_W     = 4;
    localparam int PAT_W     = 7;
    localparam int CHAR_W    = 7;

    localparam logic [LEN_W-1:0]  LEN_MAX_TOKEN = LEN_W'(MAX_TOKEN);
    localparam logic [LEN_W-1:0]  LEN_KEEP      = LEN_W'(PAT_W);
    localparam logic [LEN_W-1:0]  LEN_SAT       = '1;

    localparam logic [7:0] SYM_SPACE = 8'h20;
    localparam logic [7:0] SYM_DOT   = 8'h2E;
    localparam logic [7:0] SYM_DASH  = 8'h2D;

    localparam logic [CHAR_W-1:0] CHAR_UNKNOWN = 7'h3F;
    localparam logic [CHAR_W-1:0] CHAR_GAP     = 7'h20;

    typedef struct packed {
        logic [1:0]        count;
        logic [CHAR_W-1:0] ch0;
        logic [CHAR_W-1:0] ch1;
    } res_t;

    // Pattern bit i is symbol i of the token, dash = 1.
    function automatic logic [CHAR_W-1:0] mtd_lookup(
        input logic [PAT_W-1:0] pattern,
        input logic [LEN_W-1:0] len,
        input logic             invalid
    );
        logic [CHAR_W-1:0] ch;
        ch = CHAR_UNKNOWN;
        if (!invalid && len != '0 && len <= LEN_KEEP) begin
            unique case ({len[2:0], pattern})
                {3'd2, 7'b10}:      ch = 7'h41; // A
                {3'd4, 7'b0001}:    ch = 7'h42; // B
                {3'd4, 7'b0101}:    ch = 7'h43; // C
                {3'd3, 7'b001}:     ch = 7'h44; // D
                {3'd1, 7'b0}:       ch = 7'h45; // E
                {3'd4, 7'b0100}:    ch = 7'h46; // F
                {3'd3, 7'b011}:     ch = 7'h47; // G
                {3'd4, 7'b0000}:    ch = 7'h48; // H
                {3'd2, 7'b00}:      ch = 7'h49; // I
                {3'd4, 7'b1110}:    ch = 7'h4A; // J
                {3'd3, 7'b101}:     ch = 7'h4B; // K
                {3'd4, 7'b0010}:    ch = 7'h4C; // L
                {3'd2, 7'b11}:      ch = 7'h4D; // M
                {3'd2, 7'b01}:      ch = 7'h4E; // N
                {3'd3, 7'b111}:     ch = 7'h4F; // O
                {3'd4, 7'b0110}:    ch = 7'h50; // P
                {3'd4, 7'b1011}:    ch = 7'h51; // Q
                {3'd3, 7'b010}:     ch = 7'h52; // R
                {3'd3, 7'b000}:     ch = 7'h53; // S
                {3'd1, 7'b1}:       ch = 7'h54; // T
                {3'd3, 7'b100}:     ch = 7'h55; // U
                {3'd4, 7'b1000}:    ch = 7'h56; // V
                {3'd3, 7'b110}:     ch = 7'h57; // W
                {3'd4, 7'b1001}:    ch = 7'h58; // X
                {3'd4, 7'b1101}:    ch = 7'h59; // Y
                {3'd4, 7'b0011}:    ch = 7'h5A; // Z
                {3'd5, 7'b11111}:   ch = 7'h30;
                {3'd5, 7'b11110}:   ch = 7'h31;
                {3'd5, 7'b11100}:   ch = 7'h32;
                {3'd5, 7'b11000}:   ch = 7'h33;
                {3'd5, 7'b10000}:   ch = 7'h34;
                {3'd5, 7'b00000}:   ch = 7'h35;
                {3'd5, 7'b00001}:   ch = 7'h36;
                {3'd5, 7'b00011}:   ch = 7'h37;
                {3'd5, 7'b00111}:   ch = 7'h38;
                {3'd5, 7'b01111}:   ch = 7'h39;
                {3'd6, 7'b110011}:  ch = 7'h2C; // ,
                {3'd6, 7'b001100}:  ch = 7'h3F; // ?
                {3'd6, 7'b110101}:  ch = 7'h21; // !
                {3'd6, 7'b011110}:  ch = 7'h27; // '
                {3'd5, 7'b01001}:   ch = 7'h2F; // /
                {3'd5, 7'b01101}:   ch = 7'h28; // (
                {3'd6, 7'b101101}:  ch = 7'h29; // )
                {3'd5, 7'b00010}:   ch = 7'h26; // &
                {3'd6, 7'b000111}:  ch = 7'h3A; // :
                {3'd6, 7'b010101}:  ch = 7'h3B; // ;
                {3'd5, 7'b10001}:   ch = 7'h3D; // =
                {3'd5, 7'b01010}:   ch = 7'h2B; // +
                {3'd6, 7'b101100}:  ch = 7'h5F; // _
                {3'd6, 7'b010010}:  ch = 7'h22; // "
                {3'd7, 7'b1001000}: ch = 7'h24; // $
                {3'd6, 7'b010110}:  ch = 7'h40; // @
                default:            ch = CHAR_UNKNOWN;
            endcase
        end
        return ch;
    endfunction

endpackage

[rtl/core/morse_text_decoder.sv]
// morse_text_decoder: top level, Morse text stream in, ASCII stream out.
// Depends on mtd_pkg and mtd_token.
//
// Takes one character of Morse text per request on s_ and returns decoded ASCII on m_.
// Each character is decoded in the cycle it is accepted and yields zero, one or two
// results, which go into a four-entry result queue; a new character is taken
// every cycle while the queue has room for two results. Sustained rate is one
// character per cycle when each yields at most one result and m_tready stays high;
// two-result characters leave the single-result output port one result at a time.
// m_tlast marks the last result caused by an input character.
module morse_text_decoder import mtd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic       s_tlast,   // last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] decoded_char, [7] zero
    output logic       m_tlast    // run_last
);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    logic [CHAR_W-1:0] q_char_reg [QDEPTH];
    logic              q_last_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic [QPTR_W-1:0] wr_plus1;
    logic              s_accept, m_accept;
    res_t              result;

    assign s_tready = (cnt_reg <= QCNT_W'(QDEPTH - 2));
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = (cnt_reg != '0);
    assign m_accept = m_tvalid && m_tready;
    assign m_tdata  = {1'b0, q_char_reg[rd_reg]};
    assign m_tlast  = q_last_reg[rd_reg];
    assign wr_plus1 = wr_reg + 1'b1;

    mtd_token u_token (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_accept),
        .symbol  (s_tdata),
        .last    (s_tlast),
        .result  (result)
    );

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (s_accept) begin
            wr_next  = wr_reg + QPTR_W'(result.count);
            cnt_next = cnt_next + QCNT_W'(result.count);
        end
        if (m_accept) begin
            rd_next  = rd_reg + 1'b1;
            cnt_next = cnt_next - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && result.count != 2'd0) begin
            q_char_reg[wr_reg] <= result.ch0;
            q_last_reg[wr_reg] <= (result.count == 2'd1);
        end
        if (s_accept && result.count == 2'd2) begin
            q_char_reg[wr_plus1] <= result.ch1;
            q_last_reg[wr_plus1] <= 1'b1;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        QPTR_W'(cnt_reg) == QPTR_W'(wr_reg - rd_reg))
        else $error("queue pointers and count disagree");

    a_count_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |-> result.count != 2'd3)
        else $error("more than two results for one request");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_accept && !s_accept |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("queue count not decremented on output");

endmodule

[rtl/core/mtd_token.sv]
// mtd_token: token and space-run state, per-character decode into up to two results.
// Depends on mtd_pkg.
module mtd_token import mtd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] symbol,
    input  logic       last,
    output res_t       result
);

    logic [PAT_W-1:0] pat_reg, pat_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             inv_reg, inv_next;
    logic [1:0]       run_reg, run_next;

    logic [PAT_W-1:0]  pat_upd;
    logic [LEN_W-1:0]  len_upd;
    logic              inv_upd;
    logic [1:0]        run_upd;
    logic [CHAR_W-1:0] cur_char, new_char;
    logic [2:0]        ev;
    logic [CHAR_W-1:0] ec0, ec1, ec2;
    logic              is_space, is_dot, is_dash;

    assign is_space = (symbol == SYM_SPACE);
    assign is_dot   = (symbol == SYM_DOT);
    assign is_dash  = (symbol == SYM_DASH);
    assign cur_char = mtd_lookup(pat_reg, len_reg, inv_reg);
    assign new_char = mtd_lookup(pat_upd, len_upd, inv_upd);

    always_comb begin
        pat_upd = pat_reg;
        len_upd = len_reg;
        inv_upd = inv_reg;
        run_upd = (run_reg == 2'd3) ? run_reg : run_reg + 2'd1;
        ev      = '0;
        ec0     = CHAR_GAP;
        ec1     = cur_char;
        ec2     = new_char;
        if (is_space) begin
            pat_upd = '0;
            len_upd = '0;
            inv_upd = 1'b0;
            ec0     = cur_char;
            ec1     = CHAR_GAP;
            ev[0]   = (len_reg != '0);
            ev[1]   = last && (run_upd >= 2'd2);
        end else begin
            run_upd = '0;
            ev[0]   = (run_reg >= 2'd2);
            ev[1]   = (len_reg >= LEN_MAX_TOKEN);
            if (len_reg >= LEN_MAX_TOKEN) begin
                pat_upd = '0;
                len_upd = '0;
                inv_upd = 1'b0;
            end
            if (len_upd < LEN_KEEP) begin
                if (is_dash) begin
                    pat_upd[len_upd[2:0]] = 1'b1;
                end else if (!is_dot) begin
                    inv_upd = 1'b1;
                end
            end
            if (len_upd != LEN_SAT) begin
                len_upd = len_upd + 1'b1;
            end
            ev[2] = last;
        end
    end

    // Keep the first two emitted results in order.
    always_comb begin
        result.ch0   = ev[0] ? ec0 : (ev[1] ? ec1 : ec2);
        result.ch1   = (ev[0] && ev[1]) ? ec1 : ec2;
        result.count = 2'(ev[0]) + 2'(ev[1]) + 2'(ev[2]);
        if (ev == 3'b111) begin
            result.count = 2'd2;
        end
    end

    always_comb begin
        pat_next = pat_reg;
        len_next = len_reg;
        inv_next = inv_reg;
        run_next = run_reg;
        if (accept) begin
            if (last) begin
                pat_next = '0;
                len_next = '0;
                inv_next = 1'b0;
                run_next = '0;
            end else begin
                pat_next = pat_upd;
                len_next = len_upd;
                inv_next = inv_upd;
                run_next = run_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_reg <= '0;
            len_reg <= '0;
            inv_reg <= 1'b0;
            run_reg <= '0;
        end else begin
            pat_reg <= pat_next;
            len_reg <= len_next;
            inv_reg <= inv_next;
            run_reg <= run_next;
        end
    end

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && last |=> len_reg == '0 && run_reg == '0 && pat_reg == '0 && !inv_reg)
        else $error("state not cleared after end of message");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_MAX_TOKEN)
        else $error("token length beyond limit");

    a_space_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && is_space |=> len_reg == '0)
        else $error("space did not close token");

    a_run_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !is_space |=> run_reg == '0)
        else $error("space run not reset by non-space");

endmodule

[tb/sv/mtd_checker.sv]
`timescale 1ns / 1ps
// mtd_checker: watches both streams of morse_text_decoder and predicts each decoded character.
// Results are compared in order against the prediction; depends on mtd_pkg.
module mtd_checker import mtd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic       s_tlast,   // last
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [6:0] decoded_char, [7] zero
    input  logic       m_tlast,   // run_last
    output int         fail_count,
    output int         pending,
    output int         results_seen
);

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              tail;
    } decoded_t;

    decoded_t expected_chars [$];

    string morse_codes [52] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
        "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
        "..-", "...-", ".--", "-..-", "-.--", "--..",
        "-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
        "---..", "----.",
        "--..--", "..--..", "-.-.--", ".----.", "-..-.", "-.--.", "-.--.-", ".-...",
        "---...", "-.-.-.", "-...-", ".-.-.", "..--.-", ".-..-.", "...-..-", ".--.-."
    };
    string morse_glyphs = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789,?!'/()&:;=+_\"$@";

    logic [PAT_W-1:0] tok_pattern;
    logic [LEN_W-1:0] tok_len;
    logic             tok_bad;
    logic [1:0]       space_cnt;

    function automatic logic [CHAR_W-1:0] lookup_token();
        logic [PAT_W-1:0]  pat;
        logic [CHAR_W-1:0] ch;
        byte               glyph;
        int                r;
        int                i;
        int                n;
        ch = CHAR_UNKNOWN;
        if (!tok_bad && tok_len != '0 && tok_len <= LEN_W'(PAT_W)) begin
            for (r = 0; r < 52; r++) begin
                pat = '0;
                n = morse_codes[r].len();
                for (i = 0; i < n; i++)
                    if (morse_codes[r][i] == "-")
                        pat[i] = 1'b1;
                if (n == int'(tok_len) && pat == tok_pattern) begin
                    glyph = morse_glyphs[r];
                    ch = glyph[CHAR_W-1:0];
                end
            end
        end
        return ch;
    endfunction

    function automatic void clear_token();
        tok_pattern = '0;
        tok_len     = '0;
        tok_bad     = 1'b0;
    endfunction

    task automatic predict_symbol(input logic [7:0] sym, input logic fin);
        logic [CHAR_W-1:0] outs [$];
        decoded_t          d;
        int                i;
        int                n;
        if (sym == SYM_SPACE) begin
            if (tok_len != '0) begin
                outs.push_back(lookup_token());
                clear_token();
            end
            if (space_cnt != 2'd3)
                space_cnt++;
            if (fin && space_cnt >= 2'd2)
                outs.push_back(CHAR_GAP);
        end else begin
            if (space_cnt >= 2'd2)
                outs.push_back(CHAR_GAP);
            space_cnt = 2'd0;
            if (tok_len >= LEN_W'(MAX_TOKEN)) begin
                outs.push_back(lookup_token());
                clear_token();
            end
            if (tok_len < LEN_W'(PAT_W)) begin
                if (sym == SYM_DASH)
                    tok_pattern[tok_len[2:0]] = 1'b1;
                else if (sym != SYM_DOT)
                    tok_bad = 1'b1;
            end
            if (tok_len != '1)
                tok_len++;
            if (fin)
                outs.push_back(lookup_token());
        end
        if (fin) begin
            clear_token();
            space_cnt = 2'd0;
        end
        // At most two results per request; the last one kept carries the tail flag.
        n = (outs.size() > 2) ? 2 : outs.size();
        for (i = 0; i < n; i++) begin
            d.ch   = outs[i];
            d.tail = (i == n - 1);
            expected_chars.push_back(d);
        end
    endtask

    always @(posedge aclk) begin
        decoded_t want;
        if (!aresetn) begin
            clear_token();
            space_cnt = 2'd0;
            expected_chars.delete();
            fail_count   = 0;
            results_seen = 0;
        end else begin
            if (s_tvalid && s_tready)
                predict_symbol(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_chars.size() == 0) begin
                    $error("unexpected result: decoded_char %h run_last %b",
                           m_tdata[CHAR_W-1:0], m_tlast);
                    fail_count++;
                end else begin
                    want = expected_chars.pop_front();
                    if (m_tdata[CHAR_W-1:0] !== want.ch) begin
                        $error("decoded_char: expected %h, actual %h", want.ch,
                               m_tdata[CHAR_W-1:0]);
                        fail_count++;
                    end
                    if (m_tdata[7] !== 1'b0) begin
                        $error("tdata pad bit: expected 0, actual %b", m_tdata[7]);
                        fail_count++;
                    end
                    if (m_tlast !== want.tail) begin
                        $error("run_last: expected %b, actual %b", want.tail, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_chars.size();
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: drives Morse text requests into morse_text_decoder with random idling on both sides.
// Checking is done by mtd_checker; depends on mtd_pkg and the decoder RTL.
module tb_top;
    import mtd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1150;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] symbol
    logic       s_tlast  = 1'b0;    // last
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [6:0] decoded_char, [7] zero
    logic       m_tlast;            // run_last

    int fail_count;
    int pending;
    int results_seen;
    int cycles     = 0;
    int items_sent = 0;
    int msgs_sent  = 0;
    bit calm       = 1'b0;

    always #2 aclk = ~aclk;

    morse_text_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    mtd_checker chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else begin
                m_tready <= 1'b1;
                hold = pick_gap();
            end
        end
    end

    task automatic send_symbol(input logic [7:0] sym, input logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (fin)
            msgs_sent++;
    endtask

    task automatic send_text(input string txt, input bit fin_at_end);
        int i;
        for (i = 0; i < txt.len(); i++)
            send_symbol(txt[i], fin_at_end && (i == txt.len() - 1));
    endtask

    // Mostly well-formed words; some tokens carry a stray byte, some are pure noise.
    task automatic send_message(input int ntok, input bit trail);
        logic [7:0] msg [$];
        logic [7:0] b;
        int         t;
        int         k;
        int         len;
        int         r;
        int         pos;
        for (t = 0; t < ntok; t++) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
                for (k = 0; k < len; k++)
                    msg.push_back($urandom_range(0, 1) ? SYM_DASH : SYM_DOT);
            end else if (r < 82) begin
                len = $urandom_range(1, 6);
                pos = $urandom_range(0, len - 1);
                for (k = 0; k < len; k++) begin
                    if (k == pos) begin
                        do b = 8'($urandom_range(0, 255)); while (b == SYM_SPACE);
                        msg.push_back(b);
                    end else begin
                        msg.push_back($urandom_range(0, 1) ? SYM_DASH : SYM_DOT);
                    end
                end
            end else begin
                len = $urandom_range(1, 4);
                for (k = 0; k < len; k++)
                    msg.push_back(8'($urandom_range(0, 255)));
            end
            if (t < ntok - 1 || trail) begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    len = 1;
                else if (r < 95)
                    len = $urandom_range(2, 4);
                else
                    len = 0;
                for (k = 0; k < len; k++)
                    msg.push_back(SYM_SPACE);
            end
        end
        for (k = 0; k < msg.size(); k++)
            send_symbol(msg[k], k == msg.size() - 1);
    endtask

    initial begin
        int start_items;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_text(".-  -", 1'b1);        // letter, word gap, letter closed by last
        send_text("...-..-", 1'b1);      // longest table entry
        send_text("..........", 1'b1);   // overflow: held token emitted, new one started
        send_text(".  ", 1'b1);          // token and gap closed by a trailing space
        send_symbol(8'h00, 1'b0);        // stray bytes decode to unknown
        send_symbol(8'hFF, 1'b1);
        send_text(" ", 1'b1);            // lone space with last: nothing out

        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS) begin
            calm = (items_sent - start_items >= 400) && (items_sent - start_items < 550);
            send_message($urandom_range(1, 8), $urandom_range(0, 3) == 0);
        end
        calm = 1'b1;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (pending != 0)
            @(negedge aclk);
        repeat (20) @(negedge aclk);

        $display("Run covered %0d symbols in %0d messages, %0d decoded characters checked",
                 items_sent, msgs_sent, results_seen);
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

[morse_text_decoder.f]
rtl/core/mtd_pkg.sv
rtl/core/mtd_token.sv
rtl/core/morse_text_decoder.sv
tb/sv/mtd_checker.sv
tb/sv/tb_top.sv
